### src/fbfla_pkg.sv
// Shared types, command codes and helpers of the fixed block free list allocator.
package fbfla_pkg;

   // Command codes carried in the cmd field of an input item.
   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_REBUILD = 2'd2;

   // Operation kinds after the front end has classified an item.
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REBUILD = 2'd2;
   localparam logic [1:0] OP_REJECT  = 2'd3;

   // Depth of the queue between front end and back end.
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [9:0] block_index;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [9:0]  granted_index;
      logic [10:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] block_index;
   } op_type;

   // Status from the back end to the front end.
   typedef struct packed {
      logic done;
      logic init;
   } back_status_type;

   // Block count register saturated to the range 1..max_blocks.
   function automatic logic [31:0] eff_count(logic [10:0] bc, logic [31:0] max_blocks);
      logic [31:0] wide;
      wide = 32'(bc);
      if (wide == 32'd0) begin
         return 32'd1;
      end
      if (wide > max_blocks) begin
         return max_blocks;
      end
      return wide;
   endfunction

endpackage

### src/fixed_block_free_list_allocator_top.sv
// Top level of the fixed block free list allocator: CSR, front end, queue and back end.
// A free or rejected command strobes its result after the queue and the result register, an
// allocate after one registered link store read as well, a rebuild after a sweep with one link
// store write per cycle; busy drops with the strobe. Results are strobed for one cycle and
// cannot be stalled. After reset, busy stays high while the link store is initialized.
module fixed_block_free_list_allocator_top #(
   parameter int unsigned MAX_BLOCKS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  fbfla_pkg::req_type req_data,
   output logic               rsp_strobe,
   output fbfla_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [10:0]        csr_wdata
);
   import fbfla_pkg::*;

   logic [10:0]     block_count_ff;
   logic            push;
   op_type          push_op;
   logic            q_valid;
   op_type          q_op;
   logic            pop;
   back_status_type status;

   // Block count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= 11'd1024;
      end else if (csr_we) begin
         block_count_ff <= csr_wdata;
      end
   end

   fbfla_front #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .block_count (block_count_ff),
      .status      (status),
      .push        (push),
      .push_op     (push_op)
   );

   fbfla_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .valid   (q_valid),
      .head_op (q_op)
   );

   fbfla_back #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_op        (q_op),
      .pop         (pop),
      .block_count (block_count_ff),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

### src/fbfla_front.sv
// Front end: accepts commands, range-checks them and queues classified operations.
module fbfla_front #(
   parameter int unsigned MAX_BLOCKS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  fbfla_pkg::req_type       req_data,
   input  logic [10:0]              block_count,
   input  fbfla_pkg::back_status_type status,
   output logic                     push,
   output fbfla_pkg::op_type        push_op
);
   import fbfla_pkg::*;

   logic        busy_ff;
   logic        busy_in;
   logic [31:0] count_wide;
   logic [31:0] index_wide;

   // An item is taken when start is high, no earlier item is in flight and no reset sweep runs.
   assign busy = busy_ff | status.init;
   assign push = start & ~busy;

   // Busy covers the time from acceptance until the back end posts the result.
   always_comb begin
      busy_in = busy_ff;
      if (push) begin
         busy_in = 1'b1;
      end else if (status.done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Classification: invalid codes and out-of-range frees become rejects.
   assign count_wide = eff_count(block_count, 32'(MAX_BLOCKS));
   assign index_wide = 32'(req_data.block_index);

   always_comb begin
      push_op.block_index = req_data.block_index;
      unique case (req_data.cmd)
         CMD_ALLOC: begin
            push_op.kind = OP_ALLOC;
         end
         CMD_FREE: begin
            push_op.kind = (index_wide < count_wide) ? OP_FREE : OP_REJECT;
         end
         CMD_REBUILD: begin
            push_op.kind = OP_REBUILD;
         end
         default: begin
            push_op.kind = OP_REJECT;
         end
      endcase
   end

endmodule

### src/fbfla_queue.sv
// Short queue of classified operations between front end and back end.
module fbfla_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fbfla_pkg::op_type push_op,
   input  logic              pop,
   output logic              valid,
   output fbfla_pkg::op_type head_op
);
   import fbfla_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;
   logic               do_push;
   logic               do_pop;

   assign valid   = (fill_ff != '0);
   assign head_op = slot_ff[rd_ptr_ff];
   assign do_push = push && (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign do_pop  = pop && valid;

   // Pointer and fill bookkeeping, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### src/fbfla_back.sv
// Back end: runs operations against the link store, head and free count.
module fbfla_back #(
   parameter int unsigned MAX_BLOCKS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  fbfla_pkg::op_type          q_op,
   output logic                       pop,
   input  logic [10:0]                block_count,
   output fbfla_pkg::back_status_type status,
   output logic                       rsp_strobe,
   output fbfla_pkg::rsp_type         rsp_data
);
   import fbfla_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_BLOCKS);
   localparam int unsigned LINK_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [31:0] RESET_COUNT = (MAX_BLOCKS < 1024) ? 32'(MAX_BLOCKS) : 32'd1024;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   // Link store memory with one write port and one registered read port.
   logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [LINK_W-1:0] wr_data;
   logic              rd_en;
   logic [LINK_W-1:0] rd_data_ff;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [LINK_W-1:0] head_ff;
   logic [LINK_W-1:0] head_in;
   logic [LINK_W-1:0] free_left_ff;
   logic [LINK_W-1:0] free_left_in;
   logic [ADDR_W-1:0] sweep_ff;
   logic [ADDR_W-1:0] sweep_in;
   logic              sweep_rsp_ff;
   logic              sweep_rsp_in;
   logic              oor_ff;
   logic              oor_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic [31:0]       count_wide;
   logic [31:0]       head_wide;
   logic [31:0]       free_wide;
   logic [31:0]       index_wide;
   logic [31:0]       sweep_wide;

   assign count_wide = eff_count(block_count, 32'(MAX_BLOCKS));
   assign head_wide  = 32'(head_ff);
   assign free_wide  = 32'(free_left_ff);
   assign index_wide = 32'(q_op.block_index);
   assign sweep_wide = 32'(sweep_ff);

   assign pop = (state_ff == ST_IDLE) && q_valid;

   // Command sequencing.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      free_left_in = free_left_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      oor_in       = oor_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff[ADDR_W-1:0];
      wr_data      = head_ff;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               rsp_in.ok            = 1'b0;
               rsp_in.granted_index = 10'd0;
               rsp_in.free_count    = free_wide[10:0];
               unique case (q_op.kind)
                  OP_ALLOC: begin
                     if (free_left_ff != '0) begin
                        // Read the head's link; the head moves to it in the read state.
                        rd_en        = 1'b1;
                        oor_in       = (head_wide >= 32'(MAX_BLOCKS));
                        free_left_in = free_left_ff - 1'b1;
                        state_in     = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_FREE: begin
                     if (free_wide < count_wide) begin
                        // Push the block: its link takes the old head.
                        wr_en                = 1'b1;
                        wr_addr              = index_wide[ADDR_W-1:0];
                        wr_data              = head_ff;
                        head_in              = LINK_W'(index_wide);
                        free_left_in         = free_left_ff + 1'b1;
                        rsp_in.ok            = 1'b1;
                        rsp_in.free_count    = 11'(free_wide + 32'd1);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_REBUILD: begin
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            // A head outside the store reads as zero.
            head_in              = oor_ff ? '0 : rd_data_ff;
            rsp_in.ok            = 1'b1;
            rsp_in.granted_index = head_wide[9:0];
            rsp_in.free_count    = free_wide[10:0];
            rsp_valid_in         = 1'b1;
            state_in             = ST_IDLE;
         end
         ST_SWEEP: begin
            // Each pass writes one entry with its index plus one.
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = LINK_W'(sweep_wide + 32'd1);
            if (sweep_ff == ADDR_W'(MAX_BLOCKS - 1)) begin
               state_in = ST_IDLE;
               head_in  = '0;
               if (sweep_rsp_ff) begin
                  free_left_in         = LINK_W'(count_wide);
                  rsp_in.ok            = 1'b1;
                  rsp_in.granted_index = 10'd0;
                  rsp_in.free_count    = count_wide[10:0];
                  rsp_valid_in         = 1'b1;
               end
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state; reset starts the initializing sweep of the link store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         head_ff      <= '0;
         free_left_ff <= LINK_W'(RESET_COUNT);
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         oor_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_left_ff <= free_left_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         oor_ff       <= oor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Link store write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= link_mem[head_ff[ADDR_W-1:0]];
      end
   end

   assign status.done = rsp_valid_in;
   assign status.init = (state_ff == ST_SWEEP) && !sweep_rsp_ff;
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

endmodule

### verif/fbfla_reply_checker.sv
// Reply checker for the free list allocator: keeps its own pool state and compares each reply.
`timescale 1ns / 1ps

module fbfla_reply_checker #(
   parameter int unsigned POOL_BLOCKS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  fbfla_pkg::req_type req_data,
   input  logic               rsp_strobe,
   input  fbfla_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [10:0]        csr_wdata,
   output int                 error_count,
   output int                 pending_replies,
   output int                 replies_checked
);
   import fbfla_pkg::*;

   // Shadow copy of the pool: links, top of the free list, free blocks and the count register.
   logic [10:0] link_table [POOL_BLOCKS];
   logic [10:0] head_block;
   logic [10:0] free_left;
   logic [10:0] count_reg;

   // Replies still owed by the block, oldest first.
   rsp_type expected_replies[$];

   int errors_seen;
   int checked_seen;

   // The count register is clamped to 1..POOL_BLOCKS wherever it is used.
   function automatic logic [10:0] usable_blocks(logic [10:0] value);
      if (value == 11'd0) begin
         return 11'd1;
      end
      if (value > POOL_BLOCKS) begin
         return 11'(POOL_BLOCKS);
      end
      return value;
   endfunction

   // Every link points at the next index, the list starts at block 0 and all usable blocks are free.
   function automatic void rebuild_pool();
      for (int i = 0; i < POOL_BLOCKS; i++) begin
         link_table[i] = 11'(i + 1);
      end
      head_block = 11'd0;
      free_left = usable_blocks(count_reg);
   endfunction

   // Applies one command to the shadow pool and returns the reply it should produce.
   function automatic rsp_type predict_reply(req_type item);
      rsp_type reply;
      logic [10:0] limit;
      reply = '0;
      limit = usable_blocks(count_reg);
      case (item.cmd)
         CMD_ALLOC: begin
            // An empty pool rejects the request and leaves the state alone.
            if (free_left != 11'd0) begin
               reply.granted_index = head_block[9:0];
               free_left = free_left - 11'd1;
               // A link read past the end of the store yields zero.
               head_block = (head_block < POOL_BLOCKS) ? link_table[head_block[9:0]] : 11'd0;
               reply.ok = 1'b1;
            end
         end
         CMD_FREE: begin
            // Out-of-range indices and a full pool are rejected; double frees are not caught.
            if ({1'b0, item.block_index} < limit && free_left < limit) begin
               link_table[item.block_index] = head_block;
               head_block = {1'b0, item.block_index};
               free_left = free_left + 11'd1;
               reply.ok = 1'b1;
            end
         end
         CMD_REBUILD: begin
            rebuild_pool();
            reply.ok = 1'b1;
         end
         default: begin
            // The unused command code is rejected without any change.
         end
      endcase
      reply.free_count = free_left;
      return reply;
   endfunction

   // Watch both channels and the register port at each rising edge.
   always @(posedge clock) begin
      rsp_type wanted;
      if (reset) begin
         count_reg = 11'd1024;
         rebuild_pool();
         expected_replies.delete();
      end else begin
         // Check the reply against the oldest expectation.
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected reply ok=%0d granted=%0d free=%0d", $time,
                        rsp_data.ok, rsp_data.granted_index, rsp_data.free_count);
               errors_seen++;
            end else begin
               wanted = expected_replies.pop_front();
               checked_seen++;
               if (rsp_data.ok !== wanted.ok) begin
                  $display("%0t: ok mismatch, expected %0d, actual %0d", $time,
                           wanted.ok, rsp_data.ok);
               end
               if (rsp_data.granted_index !== wanted.granted_index) begin
                  $display("%0t: granted_index mismatch, expected %0d, actual %0d", $time,
                           wanted.granted_index, rsp_data.granted_index);
               end
               if (rsp_data.free_count !== wanted.free_count) begin
                  $display("%0t: free_count mismatch, expected %0d, actual %0d", $time,
                           wanted.free_count, rsp_data.free_count);
               end
               if (rsp_data !== wanted) begin
                  errors_seen++;
               end
            end
         end
         if (csr_we) begin
            count_reg = csr_wdata;
         end
         // Every accepted item owes exactly one reply.
         if (start && !busy) begin
            expected_replies.push_back(predict_reply(req_data));
         end
      end
      error_count <= errors_seen;
      replies_checked <= checked_seen;
      pending_replies <= expected_replies.size();
   end

endmodule

### verif/testbench.sv
// Testbench top for the free list allocator: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
   import fbfla_pkg::*;

   localparam int unsigned POOL_BLOCKS = 1024;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;

   int error_count;
   int pending_replies;
   int replies_checked;

   // Stimulus state and run statistics.
   int  usable = POOL_BLOCKS;
   bit  steady = 1'b0;
   int  items_sent = 0;
   int  alloc_sent = 0;
   int  free_sent = 0;
   int  rebuild_sent = 0;
   int  unknown_sent = 0;
   int  settings_used = 0;

   fixed_block_free_list_allocator_top #(
      .MAX_BLOCKS(POOL_BLOCKS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   fbfla_reply_checker #(
      .POOL_BLOCKS(POOL_BLOCKS)
   ) reply_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending_replies (pending_replies),
      .replies_checked (replies_checked)
   );

   always #1 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   // Free indices favor the low blocks that are likely handed out, plus the edge at the count.
   function automatic logic [9:0] pick_free_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 10'($urandom_range(0, (usable > 32) ? 31 : usable - 1));
      end
      if (r < 75) begin
         return 10'($urandom_range(0, usable - 1));
      end
      if (r < 85 && usable < POOL_BLOCKS) begin
         return 10'(usable);
      end
      return 10'($urandom);
   endfunction

   // Offer one item, hold it until accepted, then idle for a random gap.
   task automatic send_item(logic [1:0] cmd, logic [9:0] index);
      req_type item;
      int gap;
      item.cmd = cmd;
      item.block_index = index;
      gap = steady ? 0 : pick_gap();
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      items_sent++;
      case (cmd)
         CMD_ALLOC:   alloc_sent++;
         CMD_FREE:    free_sent++;
         CMD_REBUILD: rebuild_sent++;
         default:     unknown_sent++;
      endcase
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering items and wait until every reply has come back.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_replies != 0 || busy) begin
         @(posedge clock);
      end
   endtask

   // Write the block count register; only called while the block is idle.
   task automatic write_count(logic [10:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      usable = (value == 11'd0) ? 1 : ((value > POOL_BLOCKS) ? POOL_BLOCKS : int'(value));
      settings_used++;
   endtask

   initial begin
      int r;
      int phase_len;
      int burst_left;
      bit alloc_heavy;
      logic [10:0] setting;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: the pool comes out of reset full with 1024 blocks.
      send_item(CMD_FREE, 10'd5);          // full pool rejects a free
      send_item(CMD_ALLOC, 10'h3FF);
      send_item(CMD_ALLOC, 10'd0);
      send_item(CMD_FREE, 10'd0);
      send_item(CMD_FREE, 10'h3FF);        // highest index
      send_item(CMD_UNKNOWN, 10'h3FF);
      wait_idle();
      write_count(11'd0);                  // clamps to one block
      send_item(CMD_FREE, 10'd1);          // index equal to the count
      send_item(CMD_FREE, 10'd0);          // still full from the larger pool
      send_item(CMD_REBUILD, 10'h155);
      send_item(CMD_ALLOC, 10'h2AA);
      send_item(CMD_ALLOC, 10'd0);         // empty pool
      send_item(CMD_FREE, 10'd0);
      send_item(CMD_FREE, 10'd0);          // full again
      wait_idle();
      write_count(11'h7FF);                // clamps to the maximum
      send_item(CMD_FREE, 10'd0);          // double free is accepted
      send_item(CMD_ALLOC, 10'd0);
      send_item(CMD_ALLOC, 10'd0);
      send_item(CMD_REBUILD, 10'd0);
      wait_idle();
      write_count(11'd3);                  // new count applies at once, free total does not
      send_item(CMD_ALLOC, 10'd0);
      send_item(CMD_FREE, 10'd3);
      send_item(CMD_FREE, 10'd2);
      send_item(CMD_REBUILD, 10'd0);
      send_item(CMD_UNKNOWN, 10'd0);
      wait_idle();
      write_count(11'd1024);

      // Random part: phases of bursts under different pool sizes.
      while (items_sent < RANDOM_ITEMS + 25) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0:       setting = 11'd1;
            1:       setting = 11'd2;
            2:       setting = 11'd1024;
            3:       setting = 11'd0;
            4:       setting = 11'h7FF;
            5:       setting = 11'd1025;
            6:       setting = 11'($urandom_range(3, 16));
            7:       setting = 11'($urandom_range(17, 128));
            8:       setting = 11'($urandom_range(1, 1024));
            default: setting = 11'($urandom);
         endcase
         write_count(setting);
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 7) begin
            send_item(CMD_REBUILD, 10'($urandom));
         end
         phase_len = $urandom_range(20, 60);
         burst_left = 0;
         alloc_heavy = 1'b1;
         repeat (phase_len) begin
            // Allocate-heavy and free-heavy bursts, chosen at random.
            if (burst_left == 0) begin
               alloc_heavy = 1'($urandom_range(0, 1));
               burst_left = $urandom_range(1, 12);
            end
            burst_left--;
            r = $urandom_range(0, 99);
            if (r < 2) begin
               send_item(CMD_REBUILD, 10'($urandom));
            end else if (r < 5) begin
               send_item(CMD_UNKNOWN, 10'($urandom));
            end else if ((r < 81) == alloc_heavy) begin
               send_item(CMD_ALLOC, 10'($urandom));
            end else begin
               send_item(CMD_FREE, pick_free_index());
            end
         end
      end

      // Drain and let the pipeline settle.
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Covered %0d items: %0d allocate, %0d free, %0d rebuild, %0d unknown command.",
               items_sent, alloc_sent, free_sent, rebuild_sent, unknown_sent);
      $display("Used %0d block count settings and checked %0d replies.",
               settings_used, replies_checked);
      if (error_count == 0 && pending_replies == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
src/fbfla_pkg.sv
src/fbfla_front.sv
src/fbfla_queue.sv
src/fbfla_back.sv
src/fixed_block_free_list_allocator_top.sv
verif/fbfla_reply_checker.sv
verif/testbench.sv
